FILE: sv/fpa_pkg.sv
// Shared types and constants for the fixed-partition allocator.
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

  localparam int PARTITIONS_DEF = 8;

  localparam int FUNC_W     = 2;
  localparam int AMOUNT_W   = 16;
  localparam int SLOT_W     = 3;
  localparam int PID_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int TOTAL_W    = 20;
  localparam int INTERNAL_W = 19;
  localparam int EXTERNAL_W = 21;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD    = 2'd0,
    FN_REQUEST = 2'd1,
    FN_SWAP    = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 3'd0,
    ST_ALLOCATED = 3'd1,
    ST_PENDING   = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_SWAPPED   = 3'd4,
    ST_TOO_SMALL = 3'd5,
    ST_ERROR     = 3'd6
  } status_t;

  typedef struct packed {
    logic [AMOUNT_W-1:0] size;
    logic [PID_W-1:0]    owner;
    logic [AMOUNT_W-1:0] need;
  } slot_entry_t;

endpackage

`default_nettype wire

FILE: sv/fpa_if.sv
// Valid/ready channel interfaces for allocator items and results.
`timescale 1ns / 1ps
`default_nettype none

interface fpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpa_pkg::FUNC_W-1:0]    func;
  logic [fpa_pkg::AMOUNT_W-1:0]  amount;
  logic [fpa_pkg::SLOT_W-1:0]    slot_index;

  modport source (output valid, output func, output amount, output slot_index, input ready);
  modport sink   (input valid, input func, input amount, input slot_index, output ready);
endinterface

interface fpa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [fpa_pkg::STATUS_W-1:0]         status;
  logic [fpa_pkg::SLOT_W-1:0]           slot_used;
  logic [fpa_pkg::PID_W-1:0]            process_id;
  logic                                 evicted_valid;
  logic [fpa_pkg::PID_W-1:0]            evicted_id;
  logic [fpa_pkg::INTERNAL_W-1:0]       internal_frag;
  logic signed [fpa_pkg::EXTERNAL_W-1:0] external_frag;

  modport source (output valid, output status, output slot_used, output process_id,
                  output evicted_valid, output evicted_id, output internal_frag,
                  output external_frag, input ready);
  modport sink   (input valid, input status, input slot_used, input process_id,
                  input evicted_valid, input evicted_id, input internal_frag,
                  input external_frag, output ready);
endinterface

`default_nettype wire

FILE: sv/fpa_frag.sv
// Saturating internal and external fragmentation figures.
`timescale 1ns / 1ps
`default_nettype none

module fpa_frag #(
  parameter int PARTITIONS = fpa_pkg::PARTITIONS_DEF
) (
  input  logic [fpa_pkg::AMOUNT_W+$clog2(PARTITIONS+1)-1:0] part_sum,
  input  logic [fpa_pkg::AMOUNT_W+$clog2(PARTITIONS+1)-1:0] alloc_sum,
  input  logic [fpa_pkg::TOTAL_W-1:0]                        mem_total,
  output logic [fpa_pkg::INTERNAL_W-1:0]                     internal_frag,
  output logic signed [fpa_pkg::EXTERNAL_W-1:0]              external_frag
);
  import fpa_pkg::*;

  localparam int SW = AMOUNT_W + $clog2(PARTITIONS + 1);
  localparam int EW = ((SW > TOTAL_W) ? SW : TOTAL_W) + 2;
  localparam logic signed [EW-1:0] EXT_MAX = EW'(1048575);
  localparam logic signed [EW-1:0] EXT_MIN = -EW'(1048576);

  logic [SW-1:0]          diff;
  logic signed [EW-1:0]   ext_full;

  assign diff     = part_sum - alloc_sum;
  assign ext_full = $signed(EW'(mem_total) - EW'(part_sum));

  always_comb begin
    if (32'(diff) > 32'h7FFFF) begin
      internal_frag = '1;
    end else begin
      internal_frag = INTERNAL_W'(diff);
    end
    if (ext_full > EXT_MAX) begin
      external_frag = EXTERNAL_W'(EXT_MAX);
    end else if (ext_full < EXT_MIN) begin
      external_frag = EXTERNAL_W'(EXT_MIN);
    end else begin
      external_frag = EXTERNAL_W'(ext_full);
    end
  end

endmodule

`default_nettype wire

FILE: sv/fixed_partition_allocator_unit.sv
// Top level of the fixed-partition allocator with best-fit placement.
//
//   Channel   Direction  Handshake              Contents
//   in_ch     in         valid/ready            func, amount, slot_index
//   out_ch    out        valid/ready            status, slot, ids, fragmentation
//   cfg       in         cfg_wr_en, no ready    memory size
//
// One item is in work at a time; the partition table is a memory with one
// registered read port and walked by a single compare unit, one entry at a time.
// A load moves each larger partition up one index and writes itself into the gap;
// a request scans from index 0 for the first free partition that fits; a swap checks
// the one entry it names, and an item in error goes straight to the result.
// Reset is synchronous; the table needs no clearing pass.
// A new item is accepted while the previous result still waits in the output
// register; a stalled output holds the block only when the next result is due.
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_allocator_unit #(
  parameter int PARTITIONS = fpa_pkg::PARTITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  fpa_in_if.sink                        in_ch,
  fpa_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [fpa_pkg::TOTAL_W-1:0]   cfg_wr_data
);
  import fpa_pkg::*;

  localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CW = $clog2(PARTITIONS + 1);
  localparam int SW = AMOUNT_W + CW;
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LD_RD, S_LD_CHK, S_SC_RD, S_SC_CHK, S_SW_RD, S_SW_CHK, S_EMIT
  } state_t;

  state_t                  state;
  logic [TOTAL_W-1:0]      mem_total;
  logic [PARTITIONS-1:0]   slot_busy;
  logic [CW-1:0]           slot_count;
  logic [SW-1:0]           part_sum;
  logic [SW-1:0]           alloc_sum;
  logic [PID_W-1:0]        next_process;
  logic                    pending_valid;
  logic [AMOUNT_W-1:0]     pending_need;
  logic [PID_W-1:0]        pending_id;

  logic [AMOUNT_W-1:0]     amount_q;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           ptr_m1;
  logic                    fits_busy;

  status_t                 res_status;
  logic [SLOT_W-1:0]       res_slot;
  logic [PID_W-1:0]        res_pid;
  logic                    res_ev;
  logic [PID_W-1:0]        res_evid;

  logic                    out_valid;
  status_t                 out_status;
  logic [SLOT_W-1:0]       out_slot;
  logic [PID_W-1:0]        out_pid;
  logic                    out_ev;
  logic [PID_W-1:0]        out_evid;
  logic [INTERNAL_W-1:0]   out_internal;
  logic signed [EXTERNAL_W-1:0] out_external;
  logic [INTERNAL_W-1:0]   frag_internal;
  logic signed [EXTERNAL_W-1:0] frag_external;

  slot_entry_t             mem [PARTITIONS];
  slot_entry_t             rd_entry;
  slot_entry_t             mem_wdata;
  logic                    mem_we;
  logic [IW-1:0]           mem_raddr;

  logic [AMOUNT_W-1:0]     cmp_a;
  logic [AMOUNT_W-1:0]     cmp_b;
  logic                    cmp_ge;
  logic                    ld_shift;
  logic                    ptr_busy;

  assign ptr_m1   = ptr - 1'b1;
  assign ptr_busy = slot_busy[ptr[IW-1:0]];

  // The compare unit is shared: load asks size > amount, scan and swap ask size >= need.
  assign cmp_a    = (state == S_LD_CHK) ? amount_q : rd_entry.size;
  assign cmp_b    = (state == S_LD_CHK) ? rd_entry.size :
                    ((state == S_SW_CHK) ? pending_need : amount_q);
  assign cmp_ge   = (cmp_a >= cmp_b);
  assign ld_shift = (state == S_LD_CHK) && !cmp_ge;

  assign mem_raddr = (state == S_LD_RD) ? ptr_m1[IW-1:0] : ptr[IW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_entry;
    unique case (state)
      S_LD_RD: begin
        if (ptr == '0) begin
          mem_we    = 1'b1;
          mem_wdata = '{size: amount_q, owner: '0, need: '0};
        end
      end
      S_LD_CHK: begin
        mem_we = 1'b1;
        if (!ld_shift) begin
          mem_wdata = '{size: amount_q, owner: '0, need: '0};
        end
      end
      S_SC_CHK: begin
        if (!ptr_busy && cmp_ge) begin
          mem_we    = 1'b1;
          mem_wdata = '{size: rd_entry.size, owner: res_pid, need: amount_q};
        end
      end
      S_SW_CHK: begin
        if (cmp_ge) begin
          mem_we    = 1'b1;
          mem_wdata = '{size: rd_entry.size, owner: pending_id, need: pending_need};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr[IW-1:0]] <= mem_wdata;
    end
    rd_entry <= mem[mem_raddr];
  end

  fpa_frag #(
    .PARTITIONS (PARTITIONS)
  ) u_frag (
    .part_sum      (part_sum),
    .alloc_sum     (alloc_sum),
    .mem_total     (mem_total),
    .internal_frag (frag_internal),
    .external_frag (frag_external)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mem_total     <= '0;
      slot_busy     <= '0;
      slot_count    <= '0;
      part_sum      <= '0;
      alloc_sum     <= '0;
      next_process  <= '0;
      pending_valid <= 1'b0;
      pending_need  <= '0;
      pending_id    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mem_total <= cfg_wr_data;
      end
      if (out_valid && out_ch.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            amount_q   <= in_ch.amount;
            fits_busy  <= 1'b0;
            res_status <= ST_ERROR;
            res_slot   <= '0;
            res_ev     <= 1'b0;
            res_evid   <= '0;
            unique case (in_ch.func)
              FN_LOAD: begin
                res_pid <= '0;
                if (32'(slot_count) < PARTITIONS) begin
                  ptr   <= slot_count;
                  state <= S_LD_RD;
                end else begin
                  state <= S_EMIT;
                end
              end
              FN_REQUEST: begin
                ptr           <= '0;
                res_pid       <= next_process;
                next_process  <= next_process + 1'b1;
                pending_valid <= 1'b0;
                state         <= S_SC_RD;
              end
              FN_SWAP: begin
                res_pid <= '0;
                if (pending_valid && (XW'(in_ch.slot_index) < XW'(slot_count))) begin
                  ptr   <= CW'(in_ch.slot_index);
                  state <= S_SW_RD;
                end else begin
                  state <= S_EMIT;
                end
              end
              default: begin
                res_pid <= '0;
                state   <= S_EMIT;
              end
            endcase
          end
        end
        S_LD_RD: begin
          if (ptr == '0) begin
            slot_busy[ptr[IW-1:0]] <= 1'b0;
            slot_count <= slot_count + 1'b1;
            part_sum   <= part_sum + SW'(amount_q);
            res_status <= ST_LOADED;
            res_slot   <= SLOT_W'(ptr);
            state      <= S_EMIT;
          end else begin
            state <= S_LD_CHK;
          end
        end
        S_LD_CHK: begin
          if (ld_shift) begin
            slot_busy[ptr[IW-1:0]] <= slot_busy[ptr_m1[IW-1:0]];
            ptr   <= ptr_m1;
            state <= S_LD_RD;
          end else begin
            slot_busy[ptr[IW-1:0]] <= 1'b0;
            slot_count <= slot_count + 1'b1;
            part_sum   <= part_sum + SW'(amount_q);
            res_status <= ST_LOADED;
            res_slot   <= SLOT_W'(ptr);
            state      <= S_EMIT;
          end
        end
        S_SC_RD: begin
          if (ptr < slot_count) begin
            state <= S_SC_CHK;
          end else begin
            if (fits_busy) begin
              pending_valid <= 1'b1;
              pending_need  <= amount_q;
              pending_id    <= res_pid;
              res_status    <= ST_PENDING;
            end else begin
              res_status <= ST_REJECTED;
            end
            state <= S_EMIT;
          end
        end
        S_SC_CHK: begin
          if (!ptr_busy && cmp_ge) begin
            slot_busy[ptr[IW-1:0]] <= 1'b1;
            alloc_sum  <= alloc_sum + SW'(amount_q);
            res_status <= ST_ALLOCATED;
            res_slot   <= SLOT_W'(ptr);
            state      <= S_EMIT;
          end else begin
            if (ptr_busy && cmp_ge) begin
              fits_busy <= 1'b1;
            end
            ptr   <= ptr + 1'b1;
            state <= S_SC_RD;
          end
        end
        S_SW_RD: begin
          state <= S_SW_CHK;
        end
        S_SW_CHK: begin
          pending_valid <= 1'b0;
          res_slot      <= SLOT_W'(ptr);
          res_pid       <= pending_id;
          if (!cmp_ge) begin
            res_status <= ST_TOO_SMALL;
          end else begin
            res_status <= ST_SWAPPED;
            slot_busy[ptr[IW-1:0]] <= 1'b1;
            alloc_sum <= alloc_sum - (ptr_busy ? SW'(rd_entry.need) : '0)
                         + SW'(pending_need);
            res_ev    <= ptr_busy;
            res_evid  <= ptr_busy ? rd_entry.owner : '0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid    <= 1'b1;
            out_status   <= res_status;
            out_slot     <= res_slot;
            out_pid      <= res_pid;
            out_ev       <= res_ev;
            out_evid     <= res_evid;
            out_internal <= frag_internal;
            out_external <= frag_external;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.slot_used     = out_slot;
  assign out_ch.process_id    = out_pid;
  assign out_ch.evicted_valid = out_ev;
  assign out_ch.evicted_id    = out_evid;
  assign out_ch.internal_frag = out_internal;
  assign out_ch.external_frag = out_external;

endmodule

`default_nettype wire

FILE: sv/fpa_checker.sv
// Port-level assertions for the allocator and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module fpa_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fpa_pkg::STATUS_W-1:0]  status,
  input  logic [fpa_pkg::PID_W-1:0]     process_id,
  input  logic                          evicted_valid
);
  import fpa_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(process_id))
    else $error("result changed while stalled");

  // An accepted item moves the block out of idle, so ready drops after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready in the cycle after accepting an item");

  // Only a completed swap reports an evicted process.
  a_evict_only_swap: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> status == ST_SWAPPED)
    else $error("eviction reported outside a swap");

  // Loads and errors carry no process id and no eviction.
  a_no_pid_on_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_LOADED || status == ST_ERROR)
      |-> process_id == '0 && !evicted_valid)
    else $error("process fields set on a load or error result");

endmodule

bind fixed_partition_allocator_unit fpa_checker u_fpa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .process_id    (out_ch.process_id),
  .evicted_valid (out_ch.evicted_valid)
);

`default_nettype wire

FILE: sim/fixed_partition_allocator_unit_tb.sv
// Self-checking testbench for the fixed-partition allocator: best-fit, pending and swap paths.
`timescale 1ns / 1ps

import fpa_pkg::*;

typedef struct packed {
  status_t                       status;
  logic [SLOT_W-1:0]             slot;
  logic [PID_W-1:0]              pid;
  logic                          evicted;
  logic [PID_W-1:0]              evicted_pid;
  logic [INTERNAL_W-1:0]         inner;
  logic signed [EXTERNAL_W-1:0]  outer;
} alloc_outcome_t;

class allocation_tracker;
  logic [AMOUNT_W-1:0] part_size [PARTITIONS_DEF];
  bit                  part_busy [PARTITIONS_DEF];
  logic [PID_W-1:0]    part_owner[PARTITIONS_DEF];
  logic [AMOUNT_W-1:0] part_need [PARTITIONS_DEF];
  int unsigned         part_count;
  int unsigned         sized_sum;
  int unsigned         held_sum;
  logic [PID_W-1:0]    next_pid;
  bit                  wait_valid;
  logic [AMOUNT_W-1:0] wait_need;
  logic [PID_W-1:0]    wait_pid;
  logic [TOTAL_W-1:0]  total_mem;
  alloc_outcome_t      due_outcomes[$];
  int unsigned         status_seen[8];
  int unsigned         evictions;
  int unsigned         items;
  int unsigned         results;
  int unsigned         failures;

  function new();
    for (int k = 0; k < PARTITIONS_DEF; k++) begin
      part_size[k] = '0;
      part_busy[k] = 1'b0;
      part_owner[k] = '0;
      part_need[k] = '0;
    end
    for (int k = 0; k < 8; k++) status_seen[k] = 0;
    part_count = 0;
    sized_sum = 0;
    held_sum = 0;
    next_pid = '0;
    wait_valid = 1'b0;
    wait_need = '0;
    wait_pid = '0;
    total_mem = '0;
    evictions = 0;
    items = 0;
    results = 0;
    failures = 0;
  endfunction

  function void set_total(logic [TOTAL_W-1:0] value);
    total_mem = value;
  endfunction

  function alloc_outcome_t frag_outcome(status_t st, logic [SLOT_W-1:0] slot = '0,
                                        logic [PID_W-1:0] pid = '0, logic ev = 1'b0,
                                        logic [PID_W-1:0] ev_pid = '0);
    alloc_outcome_t r;
    longint spread;
    longint gap;
    spread = longint'(sized_sum) - longint'(held_sum);
    gap = longint'(total_mem) - longint'(sized_sum);
    if (spread > 524287) spread = 524287;
    if (gap > 1048575) gap = 1048575;
    if (gap < -1048576) gap = -1048576;
    r.status = st;
    r.slot = slot;
    r.pid = pid;
    r.evicted = ev;
    r.evicted_pid = ev_pid;
    r.inner = spread[INTERNAL_W-1:0];
    r.outer = gap[EXTERNAL_W-1:0];
    status_seen[int'(st)]++;
    if (ev) evictions++;
    return r;
  endfunction

  function void accept_item(logic [FUNC_W-1:0] func, logic [AMOUNT_W-1:0] amount,
                            logic [SLOT_W-1:0] idx);
    int pos;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] old_pid;
    bit fits_busy;
    items++;
    if (func == FN_LOAD) begin
      if (part_count >= PARTITIONS_DEF) begin
        due_outcomes.push_back(frag_outcome(ST_ERROR));
        return;
      end
      pos = part_count;
      while (pos > 0 && part_size[pos-1] > amount) begin
        part_size[pos] = part_size[pos-1];
        part_busy[pos] = part_busy[pos-1];
        part_owner[pos] = part_owner[pos-1];
        part_need[pos] = part_need[pos-1];
        pos--;
      end
      part_size[pos] = amount;
      part_busy[pos] = 1'b0;
      part_owner[pos] = '0;
      part_need[pos] = '0;
      part_count++;
      sized_sum += amount;
      due_outcomes.push_back(frag_outcome(ST_LOADED, SLOT_W'(pos)));
    end else if (func == FN_REQUEST) begin
      pid = next_pid;
      next_pid = next_pid + 1'b1;
      wait_valid = 1'b0;
      fits_busy = 1'b0;
      for (int k = 0; k < part_count; k++) begin
        if (!part_busy[k] && part_size[k] >= amount) begin
          part_busy[k] = 1'b1;
          part_owner[k] = pid;
          part_need[k] = amount;
          held_sum += amount;
          due_outcomes.push_back(frag_outcome(ST_ALLOCATED, SLOT_W'(k), pid));
          return;
        end
      end
      for (int k = 0; k < part_count; k++)
        if (part_busy[k] && part_size[k] >= amount) fits_busy = 1'b1;
      if (fits_busy) begin
        wait_valid = 1'b1;
        wait_need = amount;
        wait_pid = pid;
        due_outcomes.push_back(frag_outcome(ST_PENDING, '0, pid));
      end else begin
        due_outcomes.push_back(frag_outcome(ST_REJECTED, '0, pid));
      end
    end else if (func == FN_SWAP && wait_valid && idx < part_count) begin
      wait_valid = 1'b0;
      if (part_size[idx] < wait_need) begin
        due_outcomes.push_back(frag_outcome(ST_TOO_SMALL, idx, wait_pid));
      end else if (part_busy[idx]) begin
        old_pid = part_owner[idx];
        held_sum = held_sum - part_need[idx] + wait_need;
        part_owner[idx] = wait_pid;
        part_need[idx] = wait_need;
        due_outcomes.push_back(frag_outcome(ST_SWAPPED, idx, wait_pid, 1'b1, old_pid));
      end else begin
        part_busy[idx] = 1'b1;
        held_sum += wait_need;
        part_owner[idx] = wait_pid;
        part_need[idx] = wait_need;
        due_outcomes.push_back(frag_outcome(ST_SWAPPED, idx, wait_pid));
      end
    end else begin
      due_outcomes.push_back(frag_outcome(ST_ERROR));
    end
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function void check_outcome(alloc_outcome_t got);
    alloc_outcome_t want;
    results++;
    if (due_outcomes.size() == 0) begin
      note_failure($sformatf("result with no item waiting: status %0d slot %0d pid %0d",
                             got.status, got.slot, got.pid));
      return;
    end
    want = due_outcomes.pop_front();
    if (got.status !== want.status || got.slot !== want.slot || got.pid !== want.pid ||
        got.evicted !== want.evicted || got.evicted_pid !== want.evicted_pid ||
        got.inner !== want.inner || got.outer !== want.outer)
      note_failure($sformatf({"result %0d expected st %0d slot %0d pid %0d ev %0d/%0d ",
                              "int %0d ext %0d, got st %0d slot %0d pid %0d ev %0d/%0d ",
                              "int %0d ext %0d"}, results,
                             want.status, want.slot, want.pid, want.evicted,
                             want.evicted_pid, want.inner, want.outer,
                             got.status, got.slot, got.pid, got.evicted,
                             got.evicted_pid, got.inner, got.outer));
  endfunction
endclass

module fixed_partition_allocator_unit_tb;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [TOTAL_W-1:0] cfg_wr_data;
  int                 idle_pct;
  int                 stall_pct;
  int                 hold_request;
  int                 hold_left;
  int                 totals_used;
  allocation_tracker  tracker = new();

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_partition_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(logic [FUNC_W-1:0] func, logic [AMOUNT_W-1:0] amount,
                           logic [SLOT_W-1:0] idx);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.amount <= amount;
    in_ch.slot_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    tracker.accept_item(func, amount, idx);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.due_outcomes.size() != 0);
  endtask

  task automatic write_total(logic [TOTAL_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tracker.set_total(value);
    totals_used++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [AMOUNT_W-1:0] pick_amount();
    case ($urandom_range(2))
      0: pick_amount = AMOUNT_W'($urandom_range(0, 65535));
      1: pick_amount = AMOUNT_W'($urandom_range(0, 1200));
      default: pick_amount = AMOUNT_W'($urandom_range(60000, 65535));
    endcase
  endfunction

  task automatic random_mix(int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_item(FN_REQUEST, pick_amount(), SLOT_W'($urandom_range(7)));
        send_item(FN_SWAP, AMOUNT_W'($urandom_range(0, 65535)), SLOT_W'($urandom_range(7)));
        sent += 2;
      end else begin
        if (pick < 75)
          send_item(FN_REQUEST, pick_amount(), SLOT_W'($urandom_range(7)));
        else if (pick < 90)
          send_item(FN_SWAP, AMOUNT_W'($urandom_range(0, 65535)), SLOT_W'($urandom_range(7)));
        else if (pick < 95)
          send_item(FN_LOAD, AMOUNT_W'($urandom_range(0, 65535)), SLOT_W'($urandom_range(7)));
        else
          send_item(FN_UNUSED, AMOUNT_W'($urandom_range(0, 65535)), SLOT_W'($urandom_range(7)));
        sent++;
      end
    end
  endtask

  task automatic run_directed();
    send_item(FN_SWAP, 16'd0, 3'd0);
    send_item(FN_REQUEST, 16'd10, 3'd0);
    send_item(FN_UNUSED, 16'd0, 3'd0);
    send_item(FN_LOAD, 16'd500, 3'd0);
    send_item(FN_LOAD, 16'd65535, 3'd7);
    send_item(FN_LOAD, 16'd100, 3'd0);
    send_item(FN_LOAD, 16'd0, 3'd0);
    send_item(FN_REQUEST, 16'd50, 3'd0);
    send_item(FN_REQUEST, 16'd65535, 3'd0);
    // A load after the request leaves the pending process in place.
    send_item(FN_REQUEST, 16'd600, 3'd0);
    send_item(FN_SWAP, 16'd0, 3'd7);
    send_item(FN_LOAD, 16'd1000, 3'd0);
    send_item(FN_SWAP, 16'd0, 3'd3);
    send_item(FN_REQUEST, 16'd2000, 3'd0);
    send_item(FN_SWAP, 16'd0, 3'd2);
    send_item(FN_SWAP, 16'd0, 3'd4);
    send_item(FN_REQUEST, 16'd3000, 3'd0);
    send_item(FN_SWAP, 16'd0, 3'd4);
    send_item(FN_REQUEST, 16'd3000, 3'd0);
    send_item(FN_REQUEST, 16'd0, 3'd0);
    send_item(FN_SWAP, 16'd0, 3'd4);
    send_item(FN_LOAD, 16'd100, 3'd0);
    send_item(FN_LOAD, 16'd40000, 3'd0);
    send_item(FN_LOAD, 16'd7, 3'd0);
    send_item(FN_LOAD, 16'd5, 3'd0);
  endtask

  initial begin
    alloc_outcome_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.slot = out_ch.slot_used;
        got.pid = out_ch.process_id;
        got.evicted = out_ch.evicted_valid;
        got.evicted_pid = out_ch.evicted_id;
        got.inner = out_ch.internal_frag;
        got.outer = out_ch.external_frag;
        tracker.check_outcome(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.func <= FN_LOAD;
    in_ch.amount <= '0;
    in_ch.slot_index <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    rst <= 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    totals_used = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_total('0);
    run_directed();
    wait_drained();

    write_total(20'hFFFFF);
    random_mix(400);
    wait_drained();

    hold_request = 300;
    random_mix(30);
    wait_drained();

    write_total(TOTAL_W'($urandom_range(0, 20'hFFFFF)));
    idle_pct = 78;
    random_mix(400);
    wait_drained();

    write_total(20'd524280);
    idle_pct = 0;
    stall_pct = 78;
    random_mix(400);
    wait_drained();

    write_total(TOTAL_W'($urandom_range(0, 20'hFFFFF)));
    idle_pct = 29;
    stall_pct = 29;
    random_mix(400);
    wait_drained();

    repeat (40) @(posedge clk);
    $display("Run covered %0d items and %0d results under %0d memory-size settings,",
             tracker.items, tracker.results, totals_used);
    $display("%s", $sformatf({"with outcomes load %0d, alloc %0d, pend %0d, reject %0d, ",
                              "swap %0d (%0d evictions), too small %0d, error %0d."},
             tracker.status_seen[ST_LOADED], tracker.status_seen[ST_ALLOCATED],
             tracker.status_seen[ST_PENDING], tracker.status_seen[ST_REJECTED],
             tracker.status_seen[ST_SWAPPED], tracker.evictions,
             tracker.status_seen[ST_TOO_SMALL], tracker.status_seen[ST_ERROR]));
    if (tracker.failures == 0 && tracker.due_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
sv/fpa_pkg.sv
sv/fpa_if.sv
sv/fpa_frag.sv
sv/fixed_partition_allocator_unit.sv
sv/fpa_checker.sv
sim/fixed_partition_allocator_unit_tb.sv
